### rtl/mdir_pkg.sv
// ----------------------------------------------------------------------------
// mdir_pkg - shared constants and types for the index remapper
// Register indexes, flat offset width and divider cell sizing.
// ----------------------------------------------------------------------------
package mdir_pkg;

   // flat row-major offset width; offset arithmetic wraps at this width
   localparam int FLAT_BITS = 64;
   // quotient bits resolved by one divider cell
   localparam int DIV_STEP = 4;
   // packed corner register width
   localparam int CORNER_BITS = 64;
   localparam int CSR_ADDR_BITS = 3;
   localparam int RANK_BITS = 3;

   localparam int MAX_RANK_DEF = 4;
   localparam int COORD_BITS_DEF = 16;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SRC_LOW  = 3'd0,
      CSR_SRC_HIGH = 3'd1,
      CSR_TGT_LOW  = 3'd2,
      CSR_TGT_HIGH = 3'd3,
      CSR_SRC_RANK = 3'd4,
      CSR_TGT_RANK = 3'd5
   } csr_reg_type;

endpackage

### rtl/mdir_src_cell.sv
// ----------------------------------------------------------------------------
// mdir_src_cell - one source dimension of the flat offset chain
// Clamps its coordinate into the source box and folds it into the offset.
// ----------------------------------------------------------------------------
module mdir_src_cell
   import mdir_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int DIM = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           dim_used,
   input  logic [COORD_BITS-1:0]          lo,
   input  logic [COORD_BITS-1:0]          hi,
   input  logic                           vld_in,
   input  logic [MAX_RANK*COORD_BITS-1:0] coords_in,
   input  logic [FLAT_BITS-1:0]           flat_in,
   input  logic                           clamp_in,
   output logic                           vld_out,
   output logic [MAX_RANK*COORD_BITS-1:0] coords_out,
   output logic [FLAT_BITS-1:0]           flat_out,
   output logic                           clamp_out
);

   logic                           vld_ff, vld_in_d;
   logic [MAX_RANK*COORD_BITS-1:0] coords_ff;
   logic [FLAT_BITS-1:0]           flat_ff, flat_nx_in;
   logic                           clamp_ff, clamp_nx_in;
   logic [COORD_BITS-1:0]          hi_eff, crd, crd_c;
   logic [COORD_BITS:0]            ext;
   logic                           out_lo, out_hi;

   assign vld_in_d = vld_in;

   // clamp the coordinate and fold it into the offset
   always_comb begin
      hi_eff = (hi < lo) ? lo : hi;
      crd    = coords_in[DIM*COORD_BITS +: COORD_BITS];
      out_lo = crd < lo;
      out_hi = crd > hi_eff;
      crd_c  = out_lo ? lo : (out_hi ? hi_eff : crd);
      ext    = {1'b0, hi_eff} - {1'b0, lo} + {{COORD_BITS{1'b0}}, 1'b1};
      if (dim_used) begin
         flat_nx_in  = flat_in * FLAT_BITS'(ext) + FLAT_BITS'(crd_c - lo);
         clamp_nx_in = clamp_in | out_lo | out_hi;
      end else begin
         flat_nx_in  = flat_in;
         clamp_nx_in = clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coords_ff <= coords_in;
         flat_ff   <= flat_nx_in;
         clamp_ff  <= clamp_nx_in;
      end
   end

   assign vld_out    = vld_ff;
   assign coords_out = coords_ff;
   assign flat_out   = flat_ff;
   assign clamp_out  = clamp_ff;

endmodule

### rtl/mdir_div_cell.sv
// ----------------------------------------------------------------------------
// mdir_div_cell - DIV_STEP restoring division steps of one destination extent
// Shifts quotient bits into the dividend word and keeps the partial remainder.
// ----------------------------------------------------------------------------
module mdir_div_cell
   import mdir_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic [COORD_BITS:0]            divisor,
   input  logic                           vld_in,
   input  logic [FLAT_BITS-1:0]           dvd_in,
   input  logic [COORD_BITS:0]            rem_in,
   input  logic [MAX_RANK*COORD_BITS-1:0] outs_in,
   input  logic                           clamp_in,
   output logic                           vld_out,
   output logic [FLAT_BITS-1:0]           dvd_out,
   output logic [COORD_BITS:0]            rem_out,
   output logic [MAX_RANK*COORD_BITS-1:0] outs_out,
   output logic                           clamp_out
);

   logic                           vld_ff;
   logic [FLAT_BITS-1:0]           dvd_ff, dvd_nx_in;
   logic [COORD_BITS:0]            rem_ff, rem_nx_in;
   logic [MAX_RANK*COORD_BITS-1:0] outs_ff;
   logic                           clamp_ff;

   // restoring steps: bring in one dividend bit, subtract when it fits
   always_comb begin
      logic [COORD_BITS+1:0] r2;
      dvd_nx_in = dvd_in;
      rem_nx_in = rem_in;
      for (int s = 0; s < DIV_STEP; s++) begin
         r2 = {rem_nx_in, dvd_nx_in[FLAT_BITS-1]};
         if (r2 >= {1'b0, divisor}) begin
            r2 = r2 - {1'b0, divisor};
            dvd_nx_in = {dvd_nx_in[FLAT_BITS-2:0], 1'b1};
         end else begin
            dvd_nx_in = {dvd_nx_in[FLAT_BITS-2:0], 1'b0};
         end
         rem_nx_in = r2[COORD_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dvd_ff   <= dvd_nx_in;
         rem_ff   <= rem_nx_in;
         outs_ff  <= outs_in;
         clamp_ff <= clamp_in;
      end
   end

   assign vld_out   = vld_ff;
   assign dvd_out   = dvd_ff;
   assign rem_out   = rem_ff;
   assign outs_out  = outs_ff;
   assign clamp_out = clamp_ff;

endmodule

### rtl/multi_dim_index_remap_top.sv
// Throughput: one word per cycle; source cells and divider cells all advance together.
// The whole chain stalls as one while a result waits and rsp_tready is low.
// Synchronous active-high reset clears all valid bits and the registers
// (corners 0, ranks 1); no clearing pass.
// ----------------------------------------------------------------------------
// multi_dim_index_remap_top - row-major coordinate remapper between two boxes
// Source cells build the flat offset; divider cells split it into
// destination coordinates, fastest dimension first.
// ----------------------------------------------------------------------------
module multi_dim_index_remap_top
   import mdir_pkg::*;
#(
   parameter int MAX_RANK = MAX_RANK_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int DATA_W = ((MAX_RANK*COORD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CORNER_BITS-1:0]   csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // in_coord_0 .. in_coord_{MAX_RANK-1}, COORD_BITS each, from bit 0 up
   input  logic [DATA_W-1:0]        req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_coord_0 .. out_coord_{MAX_RANK-1}, COORD_BITS each, from bit 0 up
   output logic [DATA_W-1:0]        rsp_tdata,
   // was_clamped
   output logic                     rsp_tuser
);

   localparam int NCELL = FLAT_BITS / DIV_STEP;
   localparam int NDIV  = MAX_RANK * NCELL;
   localparam int VW    = MAX_RANK * COORD_BITS;

   logic [CORNER_BITS-1:0] src_low_ff, src_high_ff, tgt_low_ff, tgt_high_ff;
   logic [RANK_BITS-1:0]   src_rank_ff, tgt_rank_ff;
   logic                   adv;

   logic [COORD_BITS-1:0] src_lo [MAX_RANK];
   logic [COORD_BITS-1:0] src_hi [MAX_RANK];
   logic [COORD_BITS-1:0] tgt_lo [MAX_RANK];
   logic [COORD_BITS-1:0] tgt_hi [MAX_RANK];
   logic [COORD_BITS:0]   tgt_div [MAX_RANK];
   logic                  src_used [MAX_RANK];
   logic                  tgt_used [MAX_RANK];

   logic                 sc_vld   [MAX_RANK];
   logic [VW-1:0]        sc_crd   [MAX_RANK];
   logic [FLAT_BITS-1:0] sc_flat  [MAX_RANK];
   logic                 sc_clamp [MAX_RANK];

   logic                 dc_vld   [NDIV];
   logic [FLAT_BITS-1:0] dc_dvd   [NDIV];
   logic [COORD_BITS:0]  dc_rem   [NDIV];
   logic [VW-1:0]        dc_outs  [NDIV];
   logic                 dc_clamp [NDIV];

   logic          rsp_vld_ff;
   logic [VW-1:0] rsp_outs_ff, rsp_outs_in;
   logic          rsp_clamp_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_low_ff  <= '0;
         src_high_ff <= '0;
         tgt_low_ff  <= '0;
         tgt_high_ff <= '0;
         src_rank_ff <= RANK_BITS'(1);
         tgt_rank_ff <= RANK_BITS'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SRC_LOW:  src_low_ff  <= csr_wdata;
            CSR_SRC_HIGH: src_high_ff <= csr_wdata;
            CSR_TGT_LOW:  tgt_low_ff  <= csr_wdata;
            CSR_TGT_HIGH: tgt_high_ff <= csr_wdata;
            CSR_SRC_RANK: src_rank_ff <= csr_wdata[RANK_BITS-1:0];
            CSR_TGT_RANK: tgt_rank_ff <= csr_wdata[RANK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // unpack corners and extents per dimension
   for (genvar k = 0; k < MAX_RANK; k++) begin : g_unpack
      localparam int SH = k * COORD_BITS;
      if (SH < CORNER_BITS) begin : g_in
         assign src_lo[k] = COORD_BITS'(src_low_ff >> SH);
         assign src_hi[k] = COORD_BITS'(src_high_ff >> SH);
         assign tgt_lo[k] = COORD_BITS'(tgt_low_ff >> SH);
         assign tgt_hi[k] = COORD_BITS'(tgt_high_ff >> SH);
      end else begin : g_out
         assign src_lo[k] = '0;
         assign src_hi[k] = '0;
         assign tgt_lo[k] = '0;
         assign tgt_hi[k] = '0;
      end
      // rank zero counts as one; ranks above MAX_RANK cover every dimension
      assign src_used[k] = (k == 0) || (4'(k) < {1'b0, src_rank_ff});
      assign tgt_used[k] = (k == 0) || (4'(k) < {1'b0, tgt_rank_ff});
      // unused destination dimensions divide by one
      assign tgt_div[k] = (!tgt_used[k] || tgt_hi[k] < tgt_lo[k]) ?
                          (COORD_BITS+1)'(1) :
                          ({1'b0, tgt_hi[k]} - {1'b0, tgt_lo[k]} + (COORD_BITS+1)'(1));
   end

   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   // source chain: dimension 0 first
   for (genvar s = 0; s < MAX_RANK; s++) begin : g_src
      mdir_src_cell #(.MAX_RANK(MAX_RANK), .COORD_BITS(COORD_BITS), .DIM(s)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .dim_used  (src_used[s]),
         .lo        (src_lo[s]),
         .hi        (src_hi[s]),
         .vld_in    ((s == 0) ? req_tvalid : sc_vld[(s == 0) ? 0 : s-1]),
         .coords_in ((s == 0) ? req_tdata[VW-1:0] : sc_crd[(s == 0) ? 0 : s-1]),
         .flat_in   ((s == 0) ? '0 : sc_flat[(s == 0) ? 0 : s-1]),
         .clamp_in  ((s == 0) ? 1'b0 : sc_clamp[(s == 0) ? 0 : s-1]),
         .vld_out   (sc_vld[s]),
         .coords_out(sc_crd[s]),
         .flat_out  (sc_flat[s]),
         .clamp_out (sc_clamp[s])
      );
   end

   // divider chain: fastest destination dimension first
   for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
      localparam int J = MAX_RANK - 1 - d;
      for (genvar k = 0; k < NCELL; k++) begin : g_cell
         localparam int C = d * NCELL + k;
         logic                 vi;
         logic [FLAT_BITS-1:0] di;
         logic [COORD_BITS:0]  ri;
         logic [VW-1:0]        oi;
         logic                 ci;
         if (C == 0) begin : g_first
            assign vi = sc_vld[MAX_RANK-1];
            assign di = sc_flat[MAX_RANK-1];
            assign ri = '0;
            assign oi = '0;
            assign ci = sc_clamp[MAX_RANK-1];
         end else if (k == 0) begin : g_dstart
            // store the finished remainder of the previous dimension
            always_comb begin
               oi = dc_outs[C-1];
               oi[(J+1)*COORD_BITS +: COORD_BITS] = tgt_used[J+1] ?
                  COORD_BITS'({1'b0, tgt_lo[J+1]} + dc_rem[C-1]) : '0;
            end
            assign vi = dc_vld[C-1];
            assign di = dc_dvd[C-1];
            assign ri = '0;
            assign ci = dc_clamp[C-1];
         end else begin : g_mid
            assign vi = dc_vld[C-1];
            assign di = dc_dvd[C-1];
            assign ri = dc_rem[C-1];
            assign oi = dc_outs[C-1];
            assign ci = dc_clamp[C-1];
         end
         mdir_div_cell #(.MAX_RANK(MAX_RANK), .COORD_BITS(COORD_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .adv      (adv),
            .divisor  (tgt_div[J]),
            .vld_in   (vi),
            .dvd_in   (di),
            .rem_in   (ri),
            .outs_in  (oi),
            .clamp_in (ci),
            .vld_out  (dc_vld[C]),
            .dvd_out  (dc_dvd[C]),
            .rem_out  (dc_rem[C]),
            .outs_out (dc_outs[C]),
            .clamp_out(dc_clamp[C])
         );
      end
   end

   // store dimension 0 and hold the result word until taken
   always_comb begin
      rsp_outs_in = dc_outs[NDIV-1];
      rsp_outs_in[0 +: COORD_BITS] = COORD_BITS'({1'b0, tgt_lo[0]} + dc_rem[NDIV-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dc_vld[NDIV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_outs_ff  <= rsp_outs_in;
         rsp_clamp_ff <= dc_clamp[NDIV-1];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = DATA_W'(rsp_outs_ff);
   assign rsp_tuser  = rsp_clamp_ff;

endmodule

### rtl/mdir_checker.sv
// ----------------------------------------------------------------------------
// mdir_checker - port-level checks for the index remapper
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module mdir_checker
   import mdir_pkg::*;
#(
   parameter int DATA_W = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // the chain takes a word exactly when the result side is free
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready disagrees with result side");

   // reset empties the chain
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind multi_dim_index_remap_top mdir_checker #(.DATA_W(DATA_W)) u_mdir_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the row-major index remapper
// Drives random and corner coordinates through the stream input, predicts
// each remapped coordinate and clamp flag, and checks every output word in
// order across a series of box and rank settings written over the CSR port.
// ----------------------------------------------------------------------------
module tb
   import mdir_pkg::*;
;

   localparam int NR = 4;
   localparam int CB = 16;
   localparam int DW = NR * CB;

   typedef struct packed {
      logic        clamped;
      logic [DW-1:0] coords;
   } remap_word_type;

   // remap predictor with its own copy of the box registers
   class remap_scoreboard;
      logic [63:0] src_lo, src_hi, tgt_lo, tgt_hi;
      logic [2:0]  src_rank, tgt_rank;
      remap_word_type pending[$];
      int errors;
      int checked;

      function void reset_regs();
         src_lo = '0; src_hi = '0; tgt_lo = '0; tgt_hi = '0;
         src_rank = 3'd1; tgt_rank = 3'd1;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(csr_reg_type idx, logic [63:0] val);
         case (idx)
            CSR_SRC_LOW:  src_lo = val;
            CSR_SRC_HIGH: src_hi = val;
            CSR_TGT_LOW:  tgt_lo = val;
            CSR_TGT_HIGH: tgt_hi = val;
            CSR_SRC_RANK: src_rank = val[2:0];
            CSR_TGT_RANK: tgt_rank = val[2:0];
            default: ;
         endcase
      endfunction

      function int used_rank(logic [2:0] r);
         if (r == 0) return 1;
         if (r > NR) return NR;
         return r;
      endfunction

      // note an accepted coordinate and queue its remapped word
      function void note_coord(logic [DW-1:0] din);
         logic [63:0] flat, stride, lo, hi, c, dim, q;
         logic        big;
         remap_word_type w;
         int sr, tr;
         sr = used_rank(src_rank);
         tr = used_rank(tgt_rank);
         flat = 0; stride = 1; big = 0;
         w = '0;
         for (int i = sr - 1; i >= 0; i--) begin
            lo = src_lo[i*CB +: CB];
            hi = src_hi[i*CB +: CB];
            c  = din[i*CB +: CB];
            if (hi < lo) hi = lo;
            if (c < lo) begin c = lo; w.clamped = 1; end
            if (c > hi) begin c = hi; w.clamped = 1; end
            flat += (c - lo) * stride;
            stride *= (hi - lo + 1);
         end
         stride = 1;
         for (int i = tr - 1; i >= 0; i--) begin
            lo = tgt_lo[i*CB +: CB];
            hi = tgt_hi[i*CB +: CB];
            if (hi < lo) hi = lo;
            dim = hi - lo + 1;
            q = big ? 64'd0 : (flat / stride) % dim;
            w.coords[i*CB +: CB] = lo + q;
            if (!big) begin
               if (stride > 64'hFFFF_FFFF_FFFF_FFFF / dim) big = 1;
               else stride *= dim;
            end
         end
         pending = {pending, w};
      endfunction

      // compare an output word with the oldest prediction
      function void check_word(logic [DW-1:0] dout, logic flag);
         remap_word_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word coords=%h clamped=%b", $time, dout, flag);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         for (int i = 0; i < NR; i++)
            if (dout[i*CB +: CB] !== e.coords[i*CB +: CB]) begin
               $display("%0t: out_coord_%0d expected %h actual %h", $time, i,
                        e.coords[i*CB +: CB], dout[i*CB +: CB]);
               errors++;
            end
         if (flag !== e.clamped) begin
            $display("%0t: was_clamped expected %b actual %b", $time, e.clamped, flag);
            errors++;
         end
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          csr_we = 0;
   logic [2:0]    csr_addr = '0;
   logic [63:0]   csr_wdata = '0;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [DW-1:0] rsp_tdata;
   logic          rsp_tuser;

   remap_scoreboard remap_sb;
   bit            quiet;        // no idling in the closing part
   int            sent;

   always #6 clock = ~clock;

   multi_dim_index_remap_top dut (.*);

   // check output words and stall the receiver in bursts
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            remap_sb.check_word(rsp_tdata, rsp_tuser);
         if (reset) rsp_tready <= 0;
         else if (hold > 0) begin
            hold--;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 19) - 1;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   task automatic csr_write(csr_reg_type idx, logic [63:0] val);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val;
      @(posedge clock);
      remap_sb.write_reg(idx, val);
      csr_we <= 0;
   endtask

   // wait for all predictions to drain, then idle before the next setting
   task automatic drain();
      while (remap_sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // offer one coordinate word and hold it until accepted
   task automatic send_coord(logic [DW-1:0] d);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      remap_sb.note_coord(d);
      sent++;
   endtask

   function automatic logic [63:0] rand_corner(int span);
      logic [63:0] v;
      for (int i = 0; i < NR; i++) v[i*CB +: CB] = $urandom_range(0, span);
      return v;
   endfunction

   // coordinates mostly near the source box, with some anywhere
   function automatic logic [DW-1:0] rand_coord();
      logic [DW-1:0] v;
      int lo, hi;
      for (int i = 0; i < NR; i++) begin
         lo = remap_sb.src_lo[i*CB +: CB];
         hi = remap_sb.src_hi[i*CB +: CB];
         if ($urandom_range(0, 4) == 0) v[i*CB +: CB] = $urandom;
         else v[i*CB +: CB] = $urandom_range(lo > 2 ? lo - 2 : 0,
                                             hi < 65533 ? hi + 2 : 65535);
      end
      return v;
   endfunction

   task automatic load_boxes(logic [63:0] sl, sh, tl, th, logic [63:0] sr, tr);
      csr_write(CSR_SRC_LOW, sl);
      csr_write(CSR_SRC_HIGH, sh);
      csr_write(CSR_TGT_LOW, tl);
      csr_write(CSR_TGT_HIGH, th);
      csr_write(CSR_SRC_RANK, sr);
      csr_write(CSR_TGT_RANK, tr);
   endtask

   initial begin
      int span;
      remap_sb = new();
      remap_sb.reset_regs();
      quiet = 0; sent = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset setting: one-element boxes
      send_coord('0);
      send_coord({DW{1'b1}});
      req_tvalid <= 0;
      drain();

      // directed: full boxes, all ranks, inverted extents, rank 0 and 7
      load_boxes(64'h0, {64{1'b1}}, 64'h0, {64{1'b1}}, 4, 4);
      send_coord('0);
      send_coord({DW{1'b1}});
      send_coord(64'h5555_AAAA_5555_AAAA);
      send_coord(64'hAAAA_5555_AAAA_5555);
      req_tvalid <= 0;
      drain();
      load_boxes(64'h0004_0003_0002_0001, 64'h0008_0006_0004_0002,
                 64'h0010_0000_0005_0007, 64'h0013_0002_0001_0009, 0, 7);
      send_coord('0);
      send_coord(64'h0008_0006_0004_0002);
      send_coord(64'h0003_0007_0001_0002);
      req_tvalid <= 0;
      drain();
      load_boxes(64'h0004_0003_0002_0001, 64'h0008_0006_0004_0002,
                 64'h0010_0000_0005_0007, 64'h0013_0002_0001_0009, 7, 0);
      send_coord(64'h0000_0000_0003_0001);
      send_coord(64'h0005_0004_0003_0002);
      send_coord(64'hFFFF_FFFF_FFFF_FFFF);
      req_tvalid <= 0;
      drain();
      load_boxes(64'h0005_0005_0005_0005, 64'h0001_0001_0001_0001,
                 64'h0009_0009_0009_0009, 64'h0002_0002_0002_0002, 4, 4);
      send_coord(64'h0005_0005_0005_0005);
      send_coord(64'h0005_0006_0005_0005);
      send_coord(64'h0000_0000_0000_0000);
      req_tvalid <= 0;
      drain();

      // random phases with new boxes and ranks
      for (int ph = 0; ph < 19; ph++) begin
         span = (ph % 3 == 0) ? 65535 : 40;
         load_boxes(rand_corner(span), rand_corner(span), rand_corner(span),
                    rand_corner(span), $urandom_range(0, 7), $urandom_range(0, 7));
         if (ph == 16) quiet = 1;
         for (int n = 0; n < 50; n++) send_coord(rand_coord());
         req_tvalid <= 0;
         drain();
      end
      $display("Checked %0d words over 24 box settings, ranks 0..7,", remap_sb.checked);
      $display("inverted extents, clamping and destination wrap.");
      if (remap_sb.errors == 0 && remap_sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
